### src/dpad_pkg.sv
// ----------------------------------------------------------------------------
// dpad_pkg
// Shared types and codes for the d-pad resolver with last-input priority.
// ----------------------------------------------------------------------------
package dpad_pkg;

  localparam int KEY_W = 4;

  // event kinds
  localparam logic OP_PRESS   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // register indexes on the configuration port
  localparam logic [1:0] REG_UP    = 2'd0;
  localparam logic [1:0] REG_RIGHT = 2'd1;
  localparam logic [1:0] REG_DOWN  = 2'd2;
  localparam logic [1:0] REG_LEFT  = 2'd3;

  // register reset values
  localparam logic [KEY_W-1:0] RST_UP    = 4'd1;
  localparam logic [KEY_W-1:0] RST_RIGHT = 4'd2;
  localparam logic [KEY_W-1:0] RST_DOWN  = 4'd3;
  localparam logic [KEY_W-1:0] RST_LEFT  = 4'd4;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key_code;
  } dpad_in_t;

  typedef struct packed {
    logic [KEY_W-1:0] horizontal_dir;
    logic [KEY_W-1:0] vertical_dir;
    logic [KEY_W-1:0] first_dir;
    logic [KEY_W-1:0] second_dir;
    logic [KEY_W-1:0] newest_key;
    logic             dpad_active;
    logic [3:0]       held_count;
    logic             ignored;
  } dpad_out_t;

endpackage

### src/dpad_last_input_priority.sv
// ----------------------------------------------------------------------------
// dpad_last_input_priority
// D-pad resolver: held key flags plus an arrival-ordered key list kept in a
// small synchronous memory; opposing directions resolve to the later press.
// ----------------------------------------------------------------------------
//
//   channel   ports                             moves
//   -------   -------------------------------   ---------------------------
//   input     in_valid / in_ready / in_data     one key event item
//   result    out_valid / out_ready / out_data  one resolved state item
//   config    psel penable pwrite paddr ...     direction key codes
//
// An item is accepted in the idle state; its list then passes through the
// memory's single read port in the scan state, and the resolve state forms
// the result. The result sits in an output register, so the next item is
// taken while it waits; a resolve stalls only while the previous result is
// still unclaimed. Reset is synchronous; entries beyond the fill count are
// never used.
//
module dpad_last_input_priority
  import dpad_pkg::*;
#(
  parameter int LIST_DEPTH = 8,
  parameter int CODE_COUNT = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  // input items
  input  logic             in_valid,
  output logic             in_ready,
  input  dpad_in_t         in_data,
  // result items
  output logic             out_valid,
  input  logic             out_ready,
  output dpad_out_t        out_data,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int AW  = $clog2(LIST_DEPTH);
  localparam int CIW = $clog2(CODE_COUNT);
  localparam logic [CW-1:0] ABSENT = CW'(LIST_DEPTH);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_RESOLVE} state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CODE_COUNT-1:0] held_r, held_nxt;
  logic [CW-1:0]      lim_r, lim_nxt;
  logic [CW-1:0]      rd_i_r, rd_i_nxt;
  logic               pend_r, pend_nxt;
  logic [CW-1:0]      wr_j_r, wr_j_nxt;
  logic               rm_en_r, rm_en_nxt;
  logic [KEY_W-1:0]   rm_key_r, rm_key_nxt;
  logic               ign_r, ign_nxt;
  logic [CW-1:0]      pos_up_r, pos_up_nxt;
  logic [CW-1:0]      pos_rt_r, pos_rt_nxt;
  logic [CW-1:0]      pos_dn_r, pos_dn_nxt;
  logic [CW-1:0]      pos_lt_r, pos_lt_nxt;
  logic [KEY_W-1:0]   newest_r, newest_nxt;
  logic [KEY_W-1:0]   code_up_r, code_rt_r, code_dn_r, code_lt_r;
  logic               out_valid_r, out_valid_nxt;
  dpad_out_t          out_data_r, out_data_nxt;

  // list memory
  logic [KEY_W-1:0]   list_mem [LIST_DEPTH];
  logic [KEY_W-1:0]   mem_rdata_r;
  logic [AW-1:0]      mem_raddr;
  logic [AW-1:0]      mem_waddr;
  logic [KEY_W-1:0]   mem_wdata;
  logic               mem_we;

  // accept decode
  logic [KEY_W-1:0]   key;
  logic [CIW-1:0]     key_idx;
  logic               code_ok, key_held, ok_press, ok_rel;
  logic               in_acc, cfg_wr, issue, keep;

  // resolve
  logic               h_up, h_rt, h_dn, h_lt;
  logic               hor_any, ver_any;
  logic [KEY_W-1:0]   hor, ver;
  logic [CW-1:0]      pos_hor, pos_ver;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  assign key      = in_data.key_code;
  assign key_idx  = CIW'(key);
  assign code_ok  = (key != '0) && (int'(key) < CODE_COUNT);
  assign key_held = code_ok && held_r[key_idx];
  assign ok_press = code_ok && (in_data.opcode == OP_PRESS) && !key_held &&
                    (count_r < ABSENT);
  assign ok_rel   = (in_data.opcode == OP_RELEASE) && key_held;

  assign issue = (rd_i_r != lim_r);
  assign keep  = !(rm_en_r && (mem_rdata_r == rm_key_r));

  assign mem_raddr = rd_i_r[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_j_r[AW-1:0];
    mem_wdata = mem_rdata_r;
    if (state_r == ST_IDLE) begin
      mem_we    = in_acc && ok_press;
      mem_waddr = count_r[AW-1:0];
      mem_wdata = key;
    end else if (state_r == ST_SCAN) begin
      // write slot trails the read slot, so no same-entry overlap
      mem_we = pend_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      list_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= list_mem[mem_raddr];
  end

  // opposing keys: later arrival wins, right resp. down on a tie
  always_comb begin
    h_up = (pos_up_r != ABSENT);
    h_rt = (pos_rt_r != ABSENT);
    h_dn = (pos_dn_r != ABSENT);
    h_lt = (pos_lt_r != ABSENT);
    hor_any = h_lt || h_rt;
    ver_any = h_up || h_dn;
    if (h_lt && (!h_rt || (pos_lt_r > pos_rt_r))) begin
      hor = code_lt_r;
      pos_hor = pos_lt_r;
    end else if (h_rt) begin
      hor = code_rt_r;
      pos_hor = pos_rt_r;
    end else begin
      hor = '0;
      pos_hor = ABSENT;
    end
    if (h_up && (!h_dn || (pos_up_r > pos_dn_r))) begin
      ver = code_up_r;
      pos_ver = pos_up_r;
    end else if (h_dn) begin
      ver = code_dn_r;
      pos_ver = pos_dn_r;
    end else begin
      ver = '0;
      pos_ver = ABSENT;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    held_nxt      = held_r;
    lim_nxt       = lim_r;
    rd_i_nxt      = rd_i_r;
    pend_nxt      = pend_r;
    wr_j_nxt      = wr_j_r;
    rm_en_nxt     = rm_en_r;
    rm_key_nxt    = rm_key_r;
    ign_nxt       = ign_r;
    pos_up_nxt    = pos_up_r;
    pos_rt_nxt    = pos_rt_r;
    pos_dn_nxt    = pos_dn_r;
    pos_lt_nxt    = pos_lt_r;
    newest_nxt    = newest_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rm_key_nxt = key;
          rm_en_nxt  = ok_rel;
          ign_nxt    = !(ok_press || ok_rel);
          lim_nxt    = count_r;
          if (ok_press) begin
            held_nxt[key_idx] = 1'b1;
            lim_nxt = count_r + 1'b1;
          end
          if (ok_rel) begin
            held_nxt[key_idx] = 1'b0;
          end
          rd_i_nxt   = '0;
          pend_nxt   = 1'b0;
          wr_j_nxt   = '0;
          pos_up_nxt = ABSENT;
          pos_rt_nxt = ABSENT;
          pos_dn_nxt = ABSENT;
          pos_lt_nxt = ABSENT;
          newest_nxt = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        pend_nxt = issue;
        if (issue) begin
          rd_i_nxt = rd_i_r + 1'b1;
        end
        // compact the list and note where the direction keys now sit
        if (pend_r && keep) begin
          if (mem_rdata_r == code_up_r) pos_up_nxt = wr_j_r;
          if (mem_rdata_r == code_rt_r) pos_rt_nxt = wr_j_r;
          if (mem_rdata_r == code_dn_r) pos_dn_nxt = wr_j_r;
          if (mem_rdata_r == code_lt_r) pos_lt_nxt = wr_j_r;
          newest_nxt = mem_rdata_r;
          wr_j_nxt   = wr_j_r + 1'b1;
        end
        if (!issue && !pend_r) begin
          count_nxt = wr_j_r;
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.horizontal_dir = hor;
          out_data_nxt.vertical_dir   = ver;
          out_data_nxt.first_dir      = (pos_hor < pos_ver) ? hor : ver;
          out_data_nxt.second_dir     = (hor_any && ver_any) ?
                                        ((pos_hor > pos_ver) ? hor : ver) : '0;
          out_data_nxt.newest_key     = newest_r;
          out_data_nxt.dpad_active    = hor_any || ver_any;
          out_data_nxt.held_count     = 4'(count_r);
          out_data_nxt.ignored        = ign_r;
          state_nxt                   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      held_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      held_r      <= held_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lim_r      <= lim_nxt;
    rd_i_r     <= rd_i_nxt;
    wr_j_r     <= wr_j_nxt;
    rm_en_r    <= rm_en_nxt;
    rm_key_r   <= rm_key_nxt;
    ign_r      <= ign_nxt;
    pos_up_r   <= pos_up_nxt;
    pos_rt_r   <= pos_rt_nxt;
    pos_dn_r   <= pos_dn_nxt;
    pos_lt_r   <= pos_lt_nxt;
    newest_r   <= newest_nxt;
    out_data_r <= out_data_nxt;
  end

  // direction code registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_up_r <= RST_UP;
      code_rt_r <= RST_RIGHT;
      code_dn_r <= RST_DOWN;
      code_lt_r <= RST_LEFT;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_UP:    code_up_r <= pwdata[KEY_W-1:0];
        REG_RIGHT: code_rt_r <= pwdata[KEY_W-1:0];
        REG_DOWN:  code_dn_r <= pwdata[KEY_W-1:0];
        REG_LEFT:  code_lt_r <= pwdata[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_UP:    prdata = 32'(code_up_r);
      REG_RIGHT: prdata = 32'(code_rt_r);
      REG_DOWN:  prdata = 32'(code_dn_r);
      REG_LEFT:  prdata = 32'(code_lt_r);
      default:   prdata = '0;
    endcase
  end

  // held flags and the list agree whenever the block waits for an item
  a_flags_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(held_r) == int'(count_r)))
    else $error("held flags disagree with list count");

  a_write_trails_read: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (wr_j_r < rd_i_r))
    else $error("list write slot overtook read slot");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ABSENT)
    else $error("list count beyond depth");

  a_result_from_resolve: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESOLVE))
    else $error("result raised outside resolve");

endmodule
